[rtl/tomvm_pkg.sv]
// ----------------------------------------------------------------------------
// tomvm_pkg
// Shared types and constants of the three-operand memory VM execute block.
// ----------------------------------------------------------------------------
package tomvm_pkg;

  // default data memory depth in words
  localparam int unsigned MEM_WORDS_DEF = 4096;

  // operand word flag that marks a memory address
  localparam logic [31:0] ADDR_FLAG = 32'h8000_0000;

  // instruction opcodes, the remaining codes do nothing
  typedef enum logic [3:0] {
    CMD_ADD   = 4'h0,
    CMD_SUB   = 4'h1,
    CMD_OR    = 4'h2,
    CMD_AND   = 4'h3,
    CMD_XOR   = 4'h4,
    CMD_NOT   = 4'h5,
    CMD_SHR   = 4'h6,
    CMD_SHL   = 4'h7,
    CMD_PRHEX = 4'h8,
    CMD_PRCHR = 4'h9
  } cmd_e;

  // kind of print reported with a result item
  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_HEX  = 2'd1,
    PK_CHR  = 2'd2
  } print_kind_e;

  // command writes a result to the destination word
  function automatic logic cmd_writes(logic [3:0] cmd);
    return cmd <= 4'(CMD_SHL);
  endfunction

  // command reads the second source
  function automatic logic cmd_reads_b(logic [3:0] cmd);
    return (cmd <= 4'(CMD_SHL)) && (cmd != 4'(CMD_NOT));
  endfunction

  // command reads the first source
  function automatic logic cmd_reads_a(logic [3:0] cmd);
    return cmd <= 4'(CMD_PRCHR);
  endfunction

endpackage

[rtl/tomvm_ram.sv]
// ----------------------------------------------------------------------------
// tomvm_ram
// Data memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tomvm_ram
  import tomvm_pkg::*;
#(
  parameter int unsigned MemWords = MEM_WORDS_DEF,
  localparam int unsigned Aw = $clog2(MemWords)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [MemWords];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tomvm_alu.sv]
// ----------------------------------------------------------------------------
// tomvm_alu
// Arithmetic, logic and shift unit for the write-back commands.
// ----------------------------------------------------------------------------
module tomvm_alu
  import tomvm_pkg::*;
(
  input  logic [3:0]  cmd_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] result_o
);

  logic big_shift;

  // shift amounts of 32 or more clear the result
  assign big_shift = |b_i[31:5];

  always_comb begin
    case (cmd_e'(cmd_i))
      CMD_ADD: result_o = a_i + b_i;
      CMD_SUB: result_o = a_i - b_i;
      CMD_OR:  result_o = a_i | b_i;
      CMD_AND: result_o = a_i & b_i;
      CMD_XOR: result_o = a_i ^ b_i;
      CMD_NOT: result_o = ~a_i;
      CMD_SHR: result_o = big_shift ? 32'h0 : (a_i >> b_i[4:0]);
      CMD_SHL: result_o = big_shift ? 32'h0 : (a_i << b_i[4:0]);
      default: result_o = 32'h0;
    endcase
  end

endmodule

[rtl/three_operand_memory_vm_execute.sv]
// ----------------------------------------------------------------------------
// three_operand_memory_vm_execute
// Memory-to-memory instruction executor around one synchronous data memory.
// ----------------------------------------------------------------------------
// an item passes the read stage, the execute stage and the output register
// the single memory read port serves the first, then the second source read of
//   an item; the next item enters with that second read, write-back overlaps
// reset: a clearing pass zeroes the memory, with in_ready_o low
// a write-back that hits the next item's first source read is forwarded
module three_operand_memory_vm_execute
  import tomvm_pkg::*;
#(
  parameter int unsigned MemWords = MEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [31:0] dest_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  print_kind_o,
  output logic [31:0] print_value_o,
  output logic        read_fault_o,
  output logic        write_fault_o
);

  localparam int unsigned Aw = $clog2(MemWords);
  localparam logic [31:0] Depth = 32'(MemWords);

  // clearing pass
  logic          clr_active_q, clr_active_d;
  logic [Aw-1:0] clr_cnt_q, clr_cnt_d;

  // read stage: item under source reads
  logic        r_valid_q, r_valid_d;
  logic        r_phase_q, r_phase_d;
  logic [3:0]  r_cmd_q;
  logic [31:0] r_wa_q, r_wb_q, r_wd_q;
  logic        fwd_hit_q;
  logic [31:0] fwd_data_q;

  // execute stage
  logic        e_valid_q, e_valid_d;
  logic [3:0]  e_cmd_q;
  logic [31:0] e_a_q, e_wb_q, e_wd_q;
  logic        e_afault_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q;
  logic [31:0] pval_q;
  logic        rfault_q, wfault_q;

  // memory ports
  logic          mem_we, mem_re;
  logic [Aw-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic          stall, go_a, go_b, e_fire, in_fire;
  logic          a_oob, b_oob, d_ok, e_wen;
  logic [31:0]   a_val, b_val, alu_res;
  logic          rfault, wfault;
  logic [1:0]    kind;
  logic [31:0]   pval;

  // handshake and pipeline control
  assign stall   = e_valid_q & out_valid_q & ~out_ready_i;
  assign go_a    = r_valid_q & ~r_phase_q & ~stall;
  assign go_b    = r_valid_q & r_phase_q & ~stall;
  assign e_fire  = e_valid_q & ~stall;
  assign in_ready_o = ~clr_active_q & (~r_valid_q | go_b);
  assign in_fire = in_valid_i & in_ready_o;

  // source and destination range checks
  assign a_oob = {1'b0, r_wa_q[30:0]} >= Depth;
  assign b_oob = {1'b0, e_wb_q[30:0]} >= Depth;
  assign d_ok  = e_wd_q[31] & ({1'b0, e_wd_q[30:0]} < Depth);

  // first source value, forwarded when the last write-back hit it
  always_comb begin
    if (!r_wa_q[31]) begin
      a_val = r_wa_q;
    end else if (a_oob) begin
      a_val = 32'h0;
    end else if (fwd_hit_q) begin
      a_val = fwd_data_q;
    end else begin
      a_val = mem_rdata;
    end
  end

  // second source value, read data arrives in the execute cycle
  always_comb begin
    if (!e_wb_q[31]) begin
      b_val = e_wb_q;
    end else if (b_oob) begin
      b_val = 32'h0;
    end else begin
      b_val = mem_rdata;
    end
  end

  tomvm_alu u_alu (
    .cmd_i    (e_cmd_q),
    .a_i      (e_a_q),
    .b_i      (b_val),
    .result_o (alu_res)
  );

  // result fields of the executing item
  always_comb begin
    rfault = (cmd_reads_a(e_cmd_q) & e_afault_q) | (cmd_reads_b(e_cmd_q) & e_wb_q[31] & b_oob);
    wfault = cmd_writes(e_cmd_q) & ~d_ok;
    kind   = PK_NONE;
    pval   = 32'h0;
    case (cmd_e'(e_cmd_q))
      CMD_PRHEX: begin
        kind = PK_HEX;
        pval = e_a_q;
      end
      CMD_PRCHR: begin
        kind = PK_CHR;
        pval = e_a_q;
      end
      default: begin
        kind = PK_NONE;
        pval = 32'h0;
      end
    endcase
  end

  assign e_wen = e_fire & cmd_writes(e_cmd_q) & d_ok;

  // memory port selection
  always_comb begin
    mem_we    = e_wen;
    mem_waddr = e_wd_q[Aw-1:0];
    mem_wdata = alu_res;
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = 32'h0;
    end
    mem_re    = go_a | go_b;
    mem_raddr = go_a ? r_wa_q[Aw-1:0] : r_wb_q[Aw-1:0];
  end

  tomvm_ram #(
    .MemWords (MemWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state of control registers
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + Aw'(1);
      if (clr_cnt_q == Aw'(MemWords - 1)) begin
        clr_active_d = 1'b0;
      end
    end

    r_valid_d = r_valid_q;
    r_phase_d = r_phase_q;
    if (go_a) begin
      r_phase_d = 1'b1;
    end
    if (go_b) begin
      r_valid_d = 1'b0;
    end
    if (in_fire) begin
      r_valid_d = 1'b1;
      r_phase_d = 1'b0;
    end

    e_valid_d = e_valid_q;
    if (e_fire) begin
      e_valid_d = 1'b0;
    end
    if (go_b) begin
      e_valid_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (e_fire) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      r_valid_q    <= 1'b0;
      r_phase_q    <= 1'b0;
      e_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      r_valid_q    <= r_valid_d;
      r_phase_q    <= r_phase_d;
      e_valid_q    <= e_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r_cmd_q <= command_i;
      r_wa_q  <= operand_a_i;
      r_wb_q  <= operand_b_i;
      r_wd_q  <= dest_address_i;
    end
    if (go_a) begin
      fwd_hit_q  <= e_wen & (e_wd_q[Aw-1:0] == r_wa_q[Aw-1:0]);
      fwd_data_q <= alu_res;
    end
    if (go_b) begin
      e_cmd_q    <= r_cmd_q;
      e_a_q      <= a_val;
      e_afault_q <= r_wa_q[31] & a_oob;
      e_wb_q     <= r_wb_q;
      e_wd_q     <= r_wd_q;
    end
    if (e_fire) begin
      kind_q   <= kind;
      pval_q   <= pval;
      rfault_q <= rfault;
      wfault_q <= wfault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign print_kind_o  = kind_q;
  assign print_value_o = pval_q;
  assign read_fault_o  = rfault_q;
  assign write_fault_o = wfault_q;

endmodule

[verif/vm_execute_checker.sv]
// ----------------------------------------------------------------------------
// vm_execute_checker
// Watches both item channels of the memory-to-memory executor, keeps its own
// shadow of the data memory, predicts every result item and compares it field
// by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vm_execute_checker
  import tomvm_pkg::*;
#(
  parameter int unsigned MemWords = MEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [31:0] dest_address_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  print_kind_i,
  input  logic [31:0] print_value_i,
  input  logic        read_fault_i,
  input  logic        write_fault_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned read_faults_o,
  output int unsigned write_faults_o
);

  typedef struct packed {
    print_kind_e kind;
    logic [31:0] value;
    logic        rfault;
    logic        wfault;
  } exec_result_t;

  logic [31:0]  shadow_mem [MemWords];
  exec_result_t expected_q [$];
  exec_result_t oldest;
  int unsigned  mismatch_total = 0;
  int unsigned  checked_total = 0;
  int unsigned  rfault_total = 0;
  int unsigned  wfault_total = 0;

  initial begin
    mismatches_o   = 0;
    pending_o      = 0;
    checked_o      = 0;
    read_faults_o  = 0;
    write_faults_o = 0;
  end

  // operand word names a memory word past the end
  function automatic logic addr_beyond(input logic [31:0] word);
    return word[31] && (32'(word[30:0]) >= MemWords);
  endfunction

  // resolve an operand word to its value: immediate, memory word or zero
  function automatic logic [31:0] fetch_operand(input logic [31:0] word);
    if (!word[31]) begin
      return word;
    end
    if (addr_beyond(word)) begin
      return '0;
    end
    return shadow_mem[word[30:0]];
  endfunction

  // execute one instruction on the shadow memory and return its result item
  function automatic exec_result_t execute_instr(input logic [3:0]  cmd,
                                                 input logic [31:0] a_word,
                                                 input logic [31:0] b_word,
                                                 input logic [31:0] d_word);
    exec_result_t res;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  r;
    logic [31:0]  off;
    res = '0;
    if (cmd <= 4'(CMD_SHL)) begin
      a = fetch_operand(a_word);
      b = (cmd == 4'(CMD_NOT)) ? '0 : fetch_operand(b_word);
      res.rfault = addr_beyond(a_word) || ((cmd != 4'(CMD_NOT)) && addr_beyond(b_word));
      case (cmd)
        CMD_ADD: r = a + b;
        CMD_SUB: r = a - b;
        CMD_OR:  r = a | b;
        CMD_AND: r = a & b;
        CMD_XOR: r = a ^ b;
        CMD_NOT: r = ~a;
        CMD_SHR: r = (b >= 32) ? '0 : (a >> b[4:0]);
        default: r = (b >= 32) ? '0 : (a << b[4:0]);
      endcase
      // destination without the address flag wraps far out of range
      off = d_word - ADDR_FLAG;
      if (off >= MemWords) begin
        res.wfault = 1'b1;
      end else begin
        shadow_mem[off] = r;
      end
    end else if ((cmd == 4'(CMD_PRHEX)) || (cmd == 4'(CMD_PRCHR))) begin
      res.value  = fetch_operand(a_word);
      res.rfault = addr_beyond(a_word);
      res.kind   = (cmd == 4'(CMD_PRHEX)) ? PK_HEX : PK_CHR;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
    mismatch_total++;
  endtask

  // compare returned items with the oldest prediction, predict accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MemWords; i++) begin
        shadow_mem[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result item with nothing pending, print_value",
                          print_value_i, '0);
        end else begin
          oldest = expected_q.pop_front();
          if (print_kind_i != oldest.kind) begin
            report_mismatch("print_kind", 32'(print_kind_i), 32'(oldest.kind));
          end
          if (print_value_i != oldest.value) begin
            report_mismatch("print_value", print_value_i, oldest.value);
          end
          if (read_fault_i != oldest.rfault) begin
            report_mismatch("read_fault", 32'(read_fault_i), 32'(oldest.rfault));
          end
          if (write_fault_i != oldest.wfault) begin
            report_mismatch("write_fault", 32'(write_fault_i), 32'(oldest.wfault));
          end
          checked_total++;
          rfault_total += oldest.rfault;
          wfault_total += oldest.wfault;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(execute_instr(command_i, operand_a_i, operand_b_i,
                                           dest_address_i));
      end
    end
    mismatches_o   <= mismatch_total;
    pending_o      <= expected_q.size();
    checked_o      <= checked_total;
    read_faults_o  <= rfault_total;
    write_faults_o <= wfault_total;
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives instruction items into the memory-to-memory executor: a directed
// sweep of opcodes, fault cases and edge values, then random instructions
// aimed at a small set of memory words, under three back-pressure mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tomvm_pkg::*;

  localparam int unsigned MemWords      = MEM_WORDS_DEF;
  localparam int unsigned StallLimit    = 20000;
  localparam int unsigned ItemsPerPhase = 441;
  localparam logic [31:0] AddrPastEnd   = ADDR_FLAG + MemWords;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  command = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic [31:0] dest_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  print_kind;
  logic [31:0] print_value;
  logic        read_fault;
  logic        write_fault;

  int unsigned src_idle_pct = 19;
  int unsigned snk_idle_pct = 55;
  int unsigned quiet_cycles = 0;
  int unsigned instrs_sent = 0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned read_faults;
  int unsigned write_faults;

  always #5 clk_i = ~clk_i;

  three_operand_memory_vm_execute #(
    .MemWords(MemWords)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .operand_a_i   (operand_a),
    .operand_b_i   (operand_b),
    .dest_address_i(dest_address),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .print_kind_o  (print_kind),
    .print_value_o (print_value),
    .read_fault_o  (read_fault),
    .write_fault_o (write_fault)
  );

  vm_execute_checker #(
    .MemWords(MemWords)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .command_i     (command),
    .operand_a_i   (operand_a),
    .operand_b_i   (operand_b),
    .dest_address_i(dest_address),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .print_kind_i  (print_kind),
    .print_value_i (print_value),
    .read_fault_i  (read_fault),
    .write_fault_i (write_fault),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .read_faults_o (read_faults),
    .write_faults_o(write_faults)
  );

  // result receiver stalls at random
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // watchdog on cycles without any accepted item, covers the clearing pass
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("no item moved for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] mem_word(input int unsigned offset);
    return ADDR_FLAG | 32'(offset);
  endfunction

  // mostly a small hot set so results feed later reads, some at the top end
  function automatic int unsigned pick_offset();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(0, 15);
    end else if (roll < 90) begin
      return $urandom_range(MemWords - 1, MemWords - 16);
    end
    return $urandom_range(0, MemWords - 1);
  endfunction

  function automatic logic [31:0] random_source();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      return mem_word(pick_offset());
    end else if (roll < 55) begin
      return ADDR_FLAG | 32'($urandom_range(32'h7FFF_FFFF, MemWords));
    end else if (roll < 70) begin
      // small immediates give in-range and just-over shift amounts
      return 32'($urandom_range(0, 40));
    end
    return {1'b0, 31'($urandom())};
  endfunction

  function automatic logic [31:0] random_dest();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      return mem_word(pick_offset());
    end else if (roll < 90) begin
      return ADDR_FLAG | 32'($urandom_range(32'h7FFF_FFFF, MemWords));
    end else if (roll < 95) begin
      return {1'b0, 31'($urandom())};
    end
    return $urandom();
  endfunction

  function automatic logic [3:0] random_command();
    if ($urandom_range(0, 99) < 85) begin
      return 4'($urandom_range(0, 9));
    end
    return 4'($urandom_range(10, 15));
  endfunction

  // present one instruction item, entered and left at a falling edge
  task automatic send_instr(input logic [3:0] cmd, input logic [31:0] a_word,
                            input logic [31:0] b_word, input logic [31:0] d_word);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    operand_a    <= a_word;
    operand_b    <= b_word;
    dest_address <= d_word;
    @(posedge clk_i);
    while (!in_ready) begin
      @(posedge clk_i);
    end
    instrs_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sweep: every opcode, carries, shift limits, faults
    send_instr(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001, mem_word(0));
    send_instr(CMD_PRHEX, mem_word(0), '0, '0);
    send_instr(CMD_SUB, 32'h0000_0000, 32'h0000_0001, mem_word(1));
    send_instr(CMD_PRHEX, mem_word(1), AddrPastEnd, AddrPastEnd);
    send_instr(CMD_OR, mem_word(0), mem_word(1), mem_word(2));
    send_instr(CMD_AND, mem_word(1), 32'h5555_5555, mem_word(3));
    send_instr(CMD_XOR, mem_word(3), 32'h7FFF_FFFF, mem_word(4));
    // not reads only the first source, so a bad second one is no fault
    send_instr(CMD_NOT, mem_word(4), 32'hFFFF_FFFF, mem_word(5));
    send_instr(CMD_SHR, mem_word(1), 32'd31, mem_word(6));
    send_instr(CMD_SHR, mem_word(1), 32'd32, mem_word(7));
    send_instr(CMD_SHL, mem_word(1), mem_word(1), mem_word(8));
    send_instr(CMD_SHL, 32'd1, 32'd0, mem_word(MemWords - 1));
    send_instr(CMD_PRCHR, mem_word(MemWords - 1), '0, '0);
    send_instr(CMD_ADD, AddrPastEnd, 32'd5, mem_word(9));
    send_instr(CMD_SUB, mem_word(1), 32'hFFFF_FFFF, mem_word(10));
    send_instr(CMD_ADD, mem_word(1), mem_word(1), AddrPastEnd);
    send_instr(CMD_OR, 32'd3, 32'd4, 32'h0000_0010);
    send_instr(CMD_XOR, mem_word(2), mem_word(3), 32'hFFFF_FFFF);
    send_instr(CMD_PRHEX, AddrPastEnd, '0, '0);
    send_instr(CMD_PRCHR, 32'h7FFF_FF41, '0, '0);
    // unused opcodes touch nothing even with bad operands
    for (int op = 10; op < 16; op++) begin
      send_instr(4'(op), 32'hFFFF_FFFF, AddrPastEnd, 32'h0000_0000);
    end

    // random instructions under three stall mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 19;
          snk_idle_pct = 55;
        end
        1: begin
          src_idle_pct = 55;
          snk_idle_pct = 19;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_instr(random_command(), random_source(), random_source(), random_dest());
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the block's latency
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    $display("%0d instructions sent in a directed sweep and three stall mixes,",
             instrs_sent);
    $display("%0d result items checked, %0d with read faults, %0d with write faults",
             checked, read_faults, write_faults);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tomvm_pkg.sv
rtl/tomvm_ram.sv
rtl/tomvm_alu.sv
rtl/three_operand_memory_vm_execute.sv
verif/vm_execute_checker.sv
verif/testbench.sv
